// ===== src/mbt_pkg.sv =====
// Shared types, constants and fixed-point helpers for the MLP trainer.
`default_nettype none
package mbt_pkg;
    localparam int ACC_W = 48;
    localparam logic [15:0] ONE_Q12 = 16'd4096;
    localparam logic [15:0] LR_RESET = 16'd6554;
    localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] REG_MOMENTUM_GAIN = 2'd1;

    typedef struct packed {
        logic       clr;
        logic       mac;
        logic       sig;
        logic       osum;
        logic       dh1;
        logic       dh2;
        logic       upd_out;
        logic       wr;
        logic [6:0] idx;
    } t_cell_ctl;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Piecewise-linear sigmoid on a Q4.12 net taken from a Q24.24 accumulator.
    function automatic logic [12:0] sigm(input logic signed [ACC_W-1:0] acc);
        logic signed [15:0] x;
        logic [15:0]        a;
        logic [12:0]        y;
        x = sat16(acc >>> 12);
        a = x[15] ? (~x + 16'd1) : x;
        if (a >= 16'd20480) begin
            y = 13'd4096;
        end else if (a >= 16'd9728) begin
            y = 13'(a >> 5) + 13'd3456;
        end else if (a >= 16'd4096) begin
            y = 13'(a >> 3) + 13'd2560;
        end else begin
            y = 13'(a >> 2) + 13'd2048;
        end
        if (x[15]) begin
            y = 13'd4096 - y;
        end
        return y;
    endfunction
endpackage
`default_nettype wire

// ===== src/mbt_adj.sv =====
// Three-stage weight update unit: gradient, scaled terms, saturated new weight.
`default_nettype none
module mbt_adj (
    input  wire logic               i_clk,
    input  wire logic signed [15:0] i_src,
    input  wire logic signed [15:0] i_delta,
    input  wire logic signed [15:0] i_w,
    input  wire logic signed [15:0] i_pc,
    input  wire logic [15:0]        i_lr,
    input  wire logic [15:0]        i_mg,
    output logic signed [15:0]      o_w,
    output logic signed [15:0]      o_ch
);
    import mbt_pkg::*;

    logic signed [31:0] prod_g;
    logic signed [36:0] prod_lr;
    logic signed [32:0] prod_mg;
    logic signed [19:0] r_g;
    logic signed [20:0] r_t1;
    logic signed [16:0] r_t2;
    logic signed [21:0] ch_sum;
    logic signed [16:0] w_sum;

    assign prod_g  = i_src * i_delta;
    assign prod_lr = r_g * $signed({1'b0, i_lr});
    assign prod_mg = $signed({1'b0, i_mg}) * i_pc;

    always_ff @(posedge i_clk) begin
        r_g  <= prod_g[31:12];
        r_t1 <= prod_lr[36:16];
        r_t2 <= prod_mg[32:16];
    end

    assign ch_sum = 22'(r_t1) + 22'(r_t2);
    assign o_ch   = sat16(48'(ch_sum));
    assign w_sum  = 17'(i_w) + 17'(o_ch);
    assign o_w    = sat16(48'(w_sum));
endmodule
`default_nettype wire

// ===== src/mbt_cell.sv =====
// One hidden unit: its input weights, output weight, activation and deltas.
`default_nettype none
module mbt_cell #(
    parameter int FEATURES = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mbt_pkg::t_cell_ctl               i_ctl,
    input  wire logic signed [15:0]               i_x,
    input  wire logic signed [15:0]               i_d_o,
    input  wire logic [15:0]                      i_lr,
    input  wire logic [15:0]                      i_mg,
    input  wire logic signed [mbt_pkg::ACC_W-1:0] i_psum,
    output logic signed [mbt_pkg::ACC_W-1:0]      o_psum
);
    import mbt_pkg::*;

    localparam int AW = $clog2(FEATURES + 1);

    logic signed [15:0]      r_wh [FEATURES+1];
    logic signed [15:0]      r_pch[FEATURES+1];
    logic signed [15:0]      r_wo;
    logic signed [15:0]      r_pco;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_psum;
    logic [12:0]             r_h;
    logic signed [15:0]      r_back;
    logic [10:0]             r_hh;
    logic signed [15:0]      r_dh;

    logic [AW-1:0]      idx;
    logic signed [31:0] mac_p;
    logic signed [32:0] out_p;
    logic signed [31:0] back_p;
    logic [25:0]        hh_p;
    logic signed [27:0] dh_p;
    logic signed [15:0] a_src;
    logic signed [15:0] a_delta;
    logic signed [15:0] a_w;
    logic signed [15:0] a_pc;
    logic signed [15:0] new_w;
    logic signed [15:0] new_ch;

    assign idx    = i_ctl.idx[AW-1:0];
    assign mac_p  = i_x * r_wh[idx];
    assign out_p  = $signed({4'b0, r_h}) * r_wo;
    assign back_p = i_d_o * r_wo;
    assign hh_p   = r_h * (13'd4096 - r_h);
    assign dh_p   = r_back * $signed({1'b0, r_hh});

    assign a_src   = i_ctl.upd_out ? $signed({3'b0, r_h}) : i_x;
    assign a_delta = i_ctl.upd_out ? i_d_o : r_dh;
    assign a_w     = i_ctl.upd_out ? r_wo : r_wh[idx];
    assign a_pc    = i_ctl.upd_out ? r_pco : r_pch[idx];

    mbt_adj u_adj (
        .i_clk   (i_clk),
        .i_src   (a_src),
        .i_delta (a_delta),
        .i_w     (a_w),
        .i_pc    (a_pc),
        .i_lr    (i_lr),
        .i_mg    (i_mg),
        .o_w     (new_w),
        .o_ch    (new_ch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FEATURES; k++) begin
                r_wh[k]  <= '0;
                r_pch[k] <= '0;
            end
            r_wo  <= '0;
            r_pco <= '0;
        end else if (i_ctl.wr) begin
            if (i_ctl.upd_out) begin
                r_wo  <= new_w;
                r_pco <= new_ch;
            end else begin
                r_wh[idx]  <= new_w;
                r_pch[idx] <= new_ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + ACC_W'(mac_p);
        end
        if (i_ctl.sig) begin
            r_h <= sigm(r_acc);
        end
        // The partial output sum ripples one cell further each cycle.
        if (i_ctl.osum) begin
            r_psum <= i_psum + ACC_W'(out_p);
        end
        if (i_ctl.dh1) begin
            r_back <= back_p[27:12];
            r_hh   <= hh_p[22:12];
        end
        if (i_ctl.dh2) begin
            r_dh <= dh_p[27:12];
        end
    end

    assign o_psum = r_psum;
endmodule
`default_nettype wire

// ===== src/mlp_backprop_trainer_core.sv =====
// Top level of the one-hidden-layer sigmoid MLP trainer.
//
// Features arrive one word per accepted start (start high, busy low). A word
// without last_feature is stored unless FEATURES words are already held, and
// busy stays low. On the last feature the block runs the forward pass and
// shows output_value for exactly one cycle with o_valid; the receiver cannot
// stall it. The forward pass runs through S_FWD, S_SIGH, S_OSUM and S_SIGO
// under busy, and o_valid is registered out of S_SIGO. With func set the block
// then trains: the delta states S_DO1, S_DO2, S_DH1 and S_DH2, then S_UPD,
// which updates the output weights and bias and then each input weight and
// hidden bias in turn, all under busy. The rate is set by the row of cells, each
// with one multiply-accumulate and a three-stage update unit that walks its
// weights one at a time, and by the output sum rippling across the row.
// The configuration channel is always ready; writes belong in idle time.
// Reset clears all weights and momentum, the feature count, and sets the
// learning rate to about 0.1 and the momentum gain to zero.
`default_nettype none
module mlp_backprop_trainer_core #(
    parameter int FEATURES = 8,
    parameter int HIDDEN   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_func,
    input  wire logic [15:0] i_feature_value,
    input  wire logic [12:0] i_target_value,
    input  wire logic        i_last_feature,
    output logic             o_valid,
    output logic [12:0]      o_output_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import mbt_pkg::*;

    localparam int CNTW = $clog2(FEATURES + 1);
    localparam int FW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int IW   = $clog2(FEATURES + HIDDEN + 2);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_FWD  = 10'b0000000010,
        S_SIGH = 10'b0000000100,
        S_OSUM = 10'b0000001000,
        S_SIGO = 10'b0000010000,
        S_DO1  = 10'b0000100000,
        S_DO2  = 10'b0001000000,
        S_DH1  = 10'b0010000000,
        S_DH2  = 10'b0100000000,
        S_UPD  = 10'b1000000000
    } t_state;

    t_state             r_state;
    logic [15:0]        r_lr;
    logic [15:0]        r_mg;
    logic signed [15:0] r_fs[FEATURES];
    logic [CNTW-1:0]    r_cnt;
    logic [CNTW-1:0]    r_n;
    logic               r_train;
    logic [12:0]        r_tgt;
    logic [IW-1:0]      r_idx;
    logic [1:0]         r_sub;
    logic [12:0]        r_o;
    logic [10:0]        r_g;
    logic signed [15:0] r_do;
    logic signed [15:0] r_wob;
    logic signed [15:0] r_pcb;
    logic               r_ov;

    logic                    accept;
    logic                    acc_last;
    logic [IW-1:0]           xsel;
    logic signed [15:0]      x_bc;
    t_cell_ctl               ctl;
    logic signed [ACC_W-1:0] psum[HIDDEN+1];
    logic [25:0]             g_p;
    logic signed [14:0]      err;
    logic signed [26:0]      do_p;
    logic signed [15:0]      b_w;
    logic signed [15:0]      b_ch;
    logic                    upd_wr;
    logic                    upd_end;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign acc_last    = accept && i_last_feature;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign upd_wr      = (r_state == S_UPD) && (r_sub == 2'd2);
    assign upd_end     = upd_wr && (r_idx == IW'(FEATURES + 1));

    // During updates step zero is the output layer; step k is input k-1.
    assign xsel = (r_state == S_UPD) ? (r_idx - IW'(1)) : r_idx;

    always_comb begin
        x_bc = '0;
        if (xsel == IW'(FEATURES)) begin
            x_bc = $signed(ONE_Q12);
        end else if (xsel < IW'(r_n)) begin
            x_bc = r_fs[xsel[FW-1:0]];
        end
    end

    always_comb begin
        ctl         = '0;
        ctl.clr     = acc_last;
        ctl.mac     = (r_state == S_FWD);
        ctl.sig     = (r_state == S_SIGH);
        ctl.osum    = (r_state == S_OSUM);
        ctl.dh1     = (r_state == S_DH1);
        ctl.dh2     = (r_state == S_DH2);
        ctl.upd_out = (r_state == S_UPD) && (r_idx == '0);
        ctl.wr      = upd_wr;
        ctl.idx     = 7'(xsel);
    end

    assign psum[0] = $signed(ACC_W'(r_wob)) <<< 12;

    for (genvar j = 0; j < HIDDEN; j++) begin : g_cell
        mbt_cell #(.FEATURES(FEATURES)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_x     (x_bc),
            .i_d_o   (r_do),
            .i_lr    (r_lr),
            .i_mg    (r_mg),
            .i_psum  (psum[j]),
            .o_psum  (psum[j+1])
        );
    end

    mbt_adj u_bias_adj (
        .i_clk   (i_clk),
        .i_src   ($signed(ONE_Q12)),
        .i_delta (r_do),
        .i_w     (r_wob),
        .i_pc    (r_pcb),
        .i_lr    (r_lr),
        .i_mg    (r_mg),
        .o_w     (b_w),
        .o_ch    (b_ch)
    );

    assign g_p  = r_o * (13'd4096 - r_o);
    assign err  = $signed({2'b0, r_tgt}) - $signed({2'b0, r_o});
    assign do_p = err * $signed({1'b0, r_g});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lr    <= LR_RESET;
            r_mg    <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_wob   <= '0;
            r_pcb   <= '0;
            r_idx   <= '0;
            r_sub   <= '0;
        end else begin
            r_ov <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LEARNING_RATE: r_lr <= i_cfg_data;
                    REG_MOMENTUM_GAIN: r_mg <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (acc_last) begin
                            r_cnt   <= '0;
                            r_idx   <= '0;
                            r_state <= S_FWD;
                        end else if (r_cnt < CNTW'(FEATURES)) begin
                            r_cnt <= r_cnt + CNTW'(1);
                        end
                    end
                end
                S_FWD: begin
                    if (r_idx == IW'(FEATURES)) begin
                        r_state <= S_SIGH;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_SIGH: begin
                    r_idx   <= '0;
                    r_state <= S_OSUM;
                end
                S_OSUM: begin
                    if (r_idx == IW'(HIDDEN - 1)) begin
                        r_state <= S_SIGO;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_SIGO: begin
                    r_ov    <= 1'b1;
                    r_state <= r_train ? S_DO1 : S_IDLE;
                end
                S_DO1: r_state <= S_DO2;
                S_DO2: r_state <= S_DH1;
                S_DH1: r_state <= S_DH2;
                S_DH2: begin
                    r_idx   <= '0;
                    r_sub   <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_wr && r_idx == '0) begin
                        r_wob <= b_w;
                        r_pcb <= b_ch;
                    end
                    if (upd_end) begin
                        r_state <= S_IDLE;
                    end else if (upd_wr) begin
                        r_sub <= '0;
                        r_idx <= r_idx + IW'(1);
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_cnt < CNTW'(FEATURES)) begin
            r_fs[r_cnt[FW-1:0]] <= $signed(i_feature_value);
        end
        if (acc_last) begin
            r_n     <= (r_cnt < CNTW'(FEATURES)) ? r_cnt + CNTW'(1) : r_cnt;
            r_train <= i_func;
            r_tgt   <= i_target_value;
        end
        if (r_state == S_SIGO) begin
            r_o <= sigm(psum[HIDDEN]);
        end
        if (r_state == S_DO1) begin
            r_g <= g_p[22:12];
        end
        if (r_state == S_DO2) begin
            r_do <= 16'(do_p >>> 12);
        end
    end

    assign o_output_value = r_o;
endmodule
`default_nettype wire

// ===== src/mbt_checker.sv =====
// Port-level checks on the trainer, bound to the top level.
`default_nettype none
module mbt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_last_feature,
    input wire logic        o_valid,
    input wire logic [12:0] o_output_value
);
    // A result word lasts exactly one cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_plain_feature: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_feature) |=> !busy)
        else $error("busy after a plain feature word");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_feature) |=> busy)
        else $error("not busy after the last feature");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_output_value <= 13'd4096))
        else $error("output value above one");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy)) else $error("result without a computation");
endmodule

bind mlp_backprop_trainer_core mbt_checker u_mbt_checker (.*);
`default_nettype wire

// ===== sim/mlp_backprop_trainer_core_tb.sv =====
// Self-checking testbench for the MLP backpropagation trainer core.
`timescale 1ns / 100ps

class trainer_scoreboard;
    localparam int NF = 8;
    localparam int NH = 16;

    longint rate;
    longint gain;
    int feat_mem [NF];
    int feat_cnt;
    int hid_w [(NF + 1) * NH];
    int out_w [NH + 1];
    int hid_dw [(NF + 1) * NH];
    int out_dw [NH + 1];
    int hid_act [NH];
    logic [12:0] output_q [$];
    int errors;

    function new();
        rate = longint'(mbt_pkg::LR_RESET);
        gain = 0;
        feat_cnt = 0;
        errors = 0;
        foreach (hid_w[k]) begin
            hid_w[k] = 0;
            hid_dw[k] = 0;
        end
        foreach (out_w[k]) begin
            out_w[k] = 0;
            out_dw[k] = 0;
        end
    endfunction

    function longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function longint squash(longint net);
        longint x;
        longint a;
        longint y;
        x = clip16(net);
        a = (x < 0) ? -x : x;
        if (a >= 20480) y = 4096;
        else if (a >= 9728) y = (a >>> 5) + 3456;
        else if (a >= 4096) y = (a >>> 3) + 2560;
        else y = (a >>> 2) + 2048;
        if (x < 0) y = 4096 - y;
        return y;
    endfunction

    function void move_weight(inout int w, inout int dw, input longint src, input longint delta);
        longint g;
        longint ch;
        g = (src * delta) >>> 12;
        ch = ((g * rate) >>> 16) + ((gain * longint'(dw)) >>> 16);
        ch = clip16(ch);
        w = int'(clip16(longint'(w) + ch));
        dw = int'(ch);
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] value);
        if (index == mbt_pkg::REG_LEARNING_RATE) rate = longint'(value);
        else if (index == mbt_pkg::REG_MOMENTUM_GAIN) gain = longint'(value);
    endfunction

    // Notes one accepted word and predicts the output it causes.
    function void note_word(logic func, logic [15:0] feat, logic [12:0] tgt, logic last);
        longint x [NF + 1];
        longint acc;
        longint o;
        longint d_o;
        longint back;
        longint dh [NH];
        int n;
        if (feat_cnt < NF) begin
            feat_mem[feat_cnt] = int'($signed(feat));
            feat_cnt++;
        end
        if (!last) return;
        n = feat_cnt;
        feat_cnt = 0;
        for (int i = 0; i < NF; i++) x[i] = (i < n) ? feat_mem[i] : 0;
        x[NF] = 4096;
        for (int j = 0; j < NH; j++) begin
            acc = 0;
            for (int i = 0; i <= NF; i++) acc += x[i] * hid_w[i * NH + j];
            hid_act[j] = int'(squash(acc >>> 12));
        end
        acc = 4096 * longint'(out_w[NH]);
        for (int j = 0; j < NH; j++) acc += longint'(hid_act[j]) * out_w[j];
        o = squash(acc >>> 12);
        output_q = {output_q, o[12:0]};
        if (!func) return;
        // Deltas come first, all from the weights as they stood before this sample.
        d_o = ((longint'(tgt) - o) * ((o * (4096 - o)) >>> 12)) >>> 12;
        for (int j = 0; j < NH; j++) begin
            back = (d_o * out_w[j]) >>> 12;
            dh[j] = (back * ((longint'(hid_act[j]) * (4096 - hid_act[j])) >>> 12)) >>> 12;
        end
        for (int j = 0; j < NH; j++) move_weight(out_w[j], out_dw[j], hid_act[j], d_o);
        move_weight(out_w[NH], out_dw[NH], 4096, d_o);
        for (int i = 0; i <= NF; i++)
            for (int j = 0; j < NH; j++)
                move_weight(hid_w[i * NH + j], hid_dw[i * NH + j], x[i], dh[j]);
    endfunction

    function void check_output(logic [12:0] got);
        logic [12:0] want;
        if (output_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected output word %0d", got);
            return;
        end
        want = output_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) $display("output_value mismatch: expected %0d, got %0d", want, got);
        end
    endfunction

    function int pending();
        return output_q.size();
    endfunction
endclass

module mlp_backprop_trainer_core_tb;
    import mbt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int WORDS_PER_PHASE = 125;
    localparam logic [1:0] SPARE_INDEX = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [15:0] i_feature_value;
    logic [12:0] i_target_value;
    logic        i_last_feature;
    logic        o_valid;
    logic [12:0] o_output_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    trainer_scoreboard sb;
    int cycles = 0;
    int idle_pct;
    int words_sent;

    mlp_backprop_trainer_core i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_feature_value(i_feature_value),
        .i_target_value(i_target_value),
        .i_last_feature(i_last_feature),
        .o_valid(o_valid),
        .o_output_value(o_output_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial sb = new();

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_output(o_output_value);
    end

    task automatic send_word(logic func, logic [15:0] feat, logic [12:0] tgt, logic last);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_feature_value <= feat;
        i_target_value <= tgt;
        i_last_feature <= last;
        do @(posedge i_clk); while (busy);
        sb.note_word(func, feat, tgt, last);
        words_sent++;
    endtask

    task automatic drain_outputs();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // A training pass may still be running after the last output word.
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(int len, logic func, logic [12:0] tgt, bit wide);
        logic [15:0] feat;
        for (int k = 0; k < len; k++) begin
            feat = wide ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
            send_word(func, feat, tgt, k == len - 1);
        end
    endtask

    task automatic random_phase();
        int len;
        int stop_at;
        logic [12:0] tgt;
        stop_at = words_sent + WORDS_PER_PHASE;
        while (words_sent < stop_at) begin
            len = ($urandom_range(0, 99) < 60) ? 8 : $urandom_range(1, 10);
            tgt = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
            if ($urandom_range(0, 19) == 0) begin
                // Noise: a stray feature word that only joins the next sample.
                send_word(1'($urandom_range(0, 1)), 16'($urandom), 13'($urandom), 1'b0);
            end
            send_sample(len, $urandom_range(0, 3) != 0, tgt, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 29) == 0) begin
                start <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        words_sent = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = 1'b0;
        i_feature_value = 16'd0;
        i_target_value = 13'd0;
        i_last_feature = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_LEARNING_RATE;
        i_cfg_data = 16'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-feature and full samples, extremes, too many features.
        send_word(1'b0, 16'h7fff, 13'd4096, 1'b1);
        send_word(1'b1, 16'h8000, 13'd0, 1'b1);
        for (int k = 0; k < 8; k++)
            send_word(1'b1, (k % 2) ? 16'h7fff : 16'h8000, 13'd4096, k == 7);
        for (int k = 0; k < 10; k++)
            send_word(1'b1, 16'h1000, 13'd8191, k == 9);
        send_word(1'b1, 16'h0000, 13'd0, 1'b1);
        send_word(1'b0, 16'hffff, 13'd1, 1'b1);
        drain_outputs();
        write_reg(REG_LEARNING_RATE, 16'hffff);
        write_reg(REG_MOMENTUM_GAIN, 16'hffff);
        write_reg(SPARE_INDEX, 16'h1234);
        send_sample(8, 1'b1, 13'd4096, 1'b1);
        send_sample(3, 1'b1, 13'd0, 1'b0);

        drain_outputs();
        write_reg(REG_LEARNING_RATE, 16'd6554);
        write_reg(REG_MOMENTUM_GAIN, 16'd32768);
        idle_pct = 16;
        random_phase();

        drain_outputs();
        write_reg(REG_LEARNING_RATE, 16'd0);
        write_reg(REG_MOMENTUM_GAIN, 16'd0);
        idle_pct = 75;
        random_phase();

        drain_outputs();
        write_reg(REG_LEARNING_RATE, 16'($urandom));
        write_reg(REG_MOMENTUM_GAIN, 16'($urandom));
        idle_pct = 0;
        random_phase();

        drain_outputs();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
